// ===== src/ska_pkg.sv =====
package ska_pkg;

  localparam int KeyW   = 32;
  localparam int CountW = 7;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e               req_type;
    logic signed [KeyW-1:0]  key;
  } in_req_t;

  typedef struct packed {
    status_e                 status;
    logic [CountW-1:0]       entry_count;
  } out_rsp_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;  // latch compare flags against the incoming key
    logic ins_en;   // apply an insert: shift up from the lower-bound cell
    logic rem_en;   // apply a remove: shift down from the matching cell
  } ska_ctrl_t;

endpackage

// ===== src/sorted_key_list_core.sv =====
// Sorted key list: a bounded multiset of signed 32-bit keys kept in
// ascending order in a row of CAPACITY compare-and-shift cells.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): each request either
// inserts a key at its lower-bound position or removes the first equal key.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): exactly one
// response per request, in order, with the status and the entry count.
//
// For each request, on the accepting edge every cell compares its key with
// the request key; once the output register is free, the cells shift in one
// step and the response is registered. One request is in the cell row at a
// time: a new request is not taken until the previous one has shifted.
// While a response waits under out_stall_i, one further request is taken and
// compared, and its shift is held until the output register frees up.
// Reset empties the list at once (count cleared); no clearing pass is run.
module sorted_key_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ska_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ska_pkg::out_rsp_t  out_rsp_o
);
  import ska_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic                   busy_q, busy_d;
  in_req_t                req_q;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  out_rsp_t               rsp_q, rsp_d;

  logic                   accept;
  logic                   apply;
  logic                   full;
  logic                   found;
  ska_ctrl_t              ctrl;
  status_e                status_d;

  logic signed [KeyW-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]    cell_lt;
  logic [CAPACITY-1:0]    cell_match;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign apply      = busy_q && (!out_valid_q || !out_stall_i);
  assign full       = (count_q == CntW'(CAPACITY));
  assign found      = |cell_match;

  assign ctrl.capture = accept;
  assign ctrl.ins_en  = apply && (req_q.req_type == REQ_INSERT) && !full;
  assign ctrl.rem_en  = apply && (req_q.req_type == REQ_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KeyW-1:0] left_key;
    logic                   left_lt;
    logic signed [KeyW-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = req_q.key;
      assign left_lt  = 1'b1;
    end else begin : g_inner
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    ska_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occ_i       (CntW'(i) < count_q),
      .cmp_key_i   (in_req_i.key),
      .ins_key_i   (req_q.key),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .lt_o        (cell_lt[i]),
      .match_o     (cell_match[i])
    );
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (apply) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_NOT_FOUND;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + CntW'(1);
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          status_d = ST_REMOVED;
          count_d  = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    if (apply) begin
      out_valid_d       = 1'b1;
      rsp_d.status      = status_d;
      rsp_d.entry_count = CountW'(count_d);
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (apply) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(cell_match))
    else $error("more than one cell matches the lower bound");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && status_d == ST_INSERTED |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list by one");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && status_d == ST_FULL |-> count_q == CntW'(CAPACITY))
    else $error("insert rejected while space remains");

  a_no_capture_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !apply |=> busy_q && $stable(req_q))
    else $error("held request changed before its shift");

endmodule

// ===== src/ska_cell.sv =====
module ska_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ska_pkg::ska_ctrl_t                ctrl_i,
  input  logic                              occ_i,
  input  logic signed [ska_pkg::KeyW-1:0]   cmp_key_i,
  input  logic signed [ska_pkg::KeyW-1:0]   ins_key_i,
  input  logic signed [ska_pkg::KeyW-1:0]   left_key_i,
  input  logic                              left_lt_i,
  input  logic signed [ska_pkg::KeyW-1:0]   right_key_i,
  output logic signed [ska_pkg::KeyW-1:0]   key_o,
  output logic                              lt_o,
  output logic                              match_o
);
  import ska_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;
  logic                   lt_q, lt_d;
  logic                   eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.capture) begin
      lt_d = occ_i && (key_q < cmp_key_i);
      eq_d = occ_i && (key_q == cmp_key_i);
    end
  end

  // Cells below the lower bound hold; the rest shift towards or away from it.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en && !lt_q) begin
      key_d = left_lt_i ? ins_key_i : left_key_i;
    end else if (ctrl_i.rem_en && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign lt_o    = lt_q;
  assign match_o = !lt_q && left_lt_i && eq_q;

endmodule
